FILE: rtl/spd_pkg.sv
// Shared types and constants of the sensor packet deframer.
`default_nettype none

package spd_pkg;

    localparam logic [7:0] TYPE_DATA = 8'h02;
    localparam logic [7:0] TYPE_END  = 8'h08;

    localparam logic [15:0] RST_HEADER_WORD    = 16'hEF01;
    localparam logic [31:0] RST_DEVICE_ADDRESS = 32'hFFFF_FFFF;
    localparam logic        RST_CHECKSUM_DIS   = 1'b1;

    localparam logic [1:0] CFG_HEADER_WORD    = 2'd0;
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_CHECKSUM_DIS   = 2'd2;

    localparam logic [2:0] HUNT_LAST = 3'd5;

    typedef enum logic [2:0] {
        ROLE_TYPE    = 3'd0,
        ROLE_LEN_HI  = 3'd1,
        ROLE_LEN_LO  = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_SUM_HI  = 3'd4,
        ROLE_SUM_LO  = 3'd5,
        ROLE_LEN_ERR = 3'd6
    } t_role;

    typedef struct packed {
        logic [15:0] header_word;
        logic [31:0] device_address;
        logic        checksum_disabled;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        t_role      byte_role;
        logic       packet_last;
        logic       checksum_good;
        logic       forward_packet;
        logic       end_of_transfer;
        logic [7:0] data_packet_count;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/sensor_packet_deframer.sv
// Top level of the sensor packet deframer: configuration, input and result registers.
//
// Received link bytes enter on the input channel (i_in_valid, o_in_stall, i_rx_byte),
// one item per byte. The block hunts for the configured two header bytes and four
// address bytes; these give no result. Every byte after the address leaves on the
// output channel (o_out_valid, i_out_stall and the result fields), tagged with its
// role; the checksum low byte and a length error carry the packet verdict.
// An accepted byte sits in the input register and is parsed on its way into the result
// register, where its result is held until taken. The block takes one byte per cycle
// unless o_in_stall is high; the framing state steps once per advancing byte.
// Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data;
// the user must write them only while the block is idle; this is not enforced.
// An index past the last register is ignored.
// Synchronous reset empties both registers, returns the hunt to its start, clears
// the packet counter and loads the configuration reset values.
// While the receiver stalls, the result is held; one more byte waits in the input
// register and then o_in_stall rises until the result is taken.
`default_nettype none

module sensor_packet_deframer
    import spd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_byte_role,
    output logic             o_packet_last,
    output logic             o_checksum_good,
    output logic             o_forward_packet,
    output logic             o_end_of_transfer,
    output logic [7:0]       o_data_packet_count
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       advance;
    logic       res_valid;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_word       <= RST_HEADER_WORD;
            r_cfg.device_address    <= RST_DEVICE_ADDRESS;
            r_cfg.checksum_disabled <= RST_CHECKSUM_DIS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER_WORD:    r_cfg.header_word       <= i_cfg_data[15:0];
                CFG_DEVICE_ADDRESS: r_cfg.device_address    <= i_cfg_data;
                CFG_CHECKSUM_DIS:   r_cfg.checksum_disabled <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    spd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_byte          = r_out.out_byte;
    assign o_byte_role         = r_out.byte_role;
    assign o_packet_last       = r_out.packet_last;
    assign o_checksum_good     = r_out.checksum_good;
    assign o_forward_packet    = r_out.forward_packet;
    assign o_end_of_transfer   = r_out.end_of_transfer;
    assign o_data_packet_count = r_out.data_packet_count;

    a_last_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_packet_last) |->
            ((o_byte_role == ROLE_SUM_LO) || (o_byte_role == ROLE_LEN_ERR)))
        else $error("Packet end flagged on a byte that is not a packet end.");

    a_fwd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_forward_packet || o_checksum_good)) |-> o_packet_last)
        else $error("Packet verdict shown on a byte that does not end a packet.");

    a_eot_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_transfer) |-> o_forward_packet)
        else $error("End of transfer flagged on a packet that is not forwarded.");

    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("Input stalled while the result register could take an item.");

endmodule

`default_nettype wire

FILE: rtl/spd_parser.sv
// Header hunt and packet field parser: holds the framing state and steps it once per byte.
`default_nettype none

module spd_parser
    import spd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    logic [2:0]  r_hunt, n_hunt;
    logic        r_in_packet, n_in_packet;
    logic [16:0] r_bpos, n_bpos;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_follow, n_follow;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_sum_hi, n_sum_hi;
    logic [7:0]  r_count, n_count;

    logic [7:0]  expected;
    logic [16:0] sum_hi_pos;
    logic [15:0] received;
    logic        good;
    logic        type_ok;
    logic        fwd;

    always_comb begin
        case (r_hunt)
            3'd0:    expected = i_cfg.header_word[15:8];
            3'd1:    expected = i_cfg.header_word[7:0];
            3'd2:    expected = i_cfg.device_address[31:24];
            3'd3:    expected = i_cfg.device_address[23:16];
            3'd4:    expected = i_cfg.device_address[15:8];
            3'd5:    expected = i_cfg.device_address[7:0];
            default: expected = 8'h00;
        endcase
    end

    assign sum_hi_pos = {1'b0, r_follow} + 17'd1;
    assign received   = {r_sum_hi, i_byte};
    assign good       = (received == r_sum);
    assign type_ok    = (r_type == TYPE_DATA) || (r_type == TYPE_END);
    assign fwd        = (good || i_cfg.checksum_disabled) && type_ok;

    always_comb begin
        n_hunt      = r_hunt;
        n_in_packet = r_in_packet;
        n_bpos      = r_bpos;
        n_type      = r_type;
        n_follow    = r_follow;
        n_sum       = r_sum;
        n_sum_hi    = r_sum_hi;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res.byte_role       = ROLE_TYPE;
        o_res.packet_last     = 1'b0;
        o_res.checksum_good   = 1'b0;
        o_res.forward_packet  = 1'b0;
        o_res.end_of_transfer = 1'b0;
        if (!r_in_packet) begin
            if ((r_hunt <= HUNT_LAST) && (i_byte == expected)) begin
                n_hunt = r_hunt + 3'd1;
                if (r_hunt == HUNT_LAST) begin
                    n_in_packet = 1'b1;
                    n_bpos      = 17'd0;
                end
            end else begin
                n_hunt = 3'd0;
            end
        end else begin
            o_res_valid = 1'b1;
            if (r_bpos == 17'd0) begin
                n_type = i_byte;
                n_sum  = {8'h00, i_byte};
                n_bpos = 17'd1;
                o_res.byte_role = ROLE_TYPE;
            end else if (r_bpos == 17'd1) begin
                n_follow = {i_byte, 8'h00};
                n_sum    = r_sum + {8'h00, i_byte};
                n_bpos   = 17'd2;
                o_res.byte_role = ROLE_LEN_HI;
            end else if (r_bpos == 17'd2) begin
                n_follow = {r_follow[15:8], i_byte};
                n_sum    = r_sum + {8'h00, i_byte};
                if ((r_follow[15:8] == 8'h00) && (i_byte[7:1] == 7'd0)) begin
                    n_in_packet = 1'b0;
                    n_hunt      = 3'd0;
                    n_bpos      = 17'd0;
                    o_res.byte_role   = ROLE_LEN_ERR;
                    o_res.packet_last = 1'b1;
                end else begin
                    n_bpos = 17'd3;
                    o_res.byte_role = ROLE_LEN_LO;
                end
            end else if (r_bpos < sum_hi_pos) begin
                n_sum  = r_sum + {8'h00, i_byte};
                n_bpos = r_bpos + 17'd1;
                o_res.byte_role = ROLE_PAYLOAD;
            end else if (r_bpos == sum_hi_pos) begin
                n_sum_hi = i_byte;
                n_bpos   = r_bpos + 17'd1;
                o_res.byte_role = ROLE_SUM_HI;
            end else begin
                if (fwd && (r_type == TYPE_DATA)) begin
                    n_count = r_count + 8'd1;
                end
                n_in_packet = 1'b0;
                n_hunt      = 3'd0;
                n_bpos      = 17'd0;
                o_res.byte_role       = ROLE_SUM_LO;
                o_res.packet_last     = 1'b1;
                o_res.checksum_good   = good;
                o_res.forward_packet  = fwd;
                o_res.end_of_transfer = fwd && (r_type == TYPE_END);
            end
        end
        o_res.out_byte          = i_byte;
        o_res.data_packet_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt      <= 3'd0;
            r_in_packet <= 1'b0;
            r_bpos      <= 17'd0;
            r_type      <= 8'h00;
            r_follow    <= 16'h0000;
            r_sum       <= 16'h0000;
            r_sum_hi    <= 8'h00;
            r_count     <= 8'h00;
        end else if (i_step) begin
            r_hunt      <= n_hunt;
            r_in_packet <= n_in_packet;
            r_bpos      <= n_bpos;
            r_type      <= n_type;
            r_follow    <= n_follow;
            r_sum       <= n_sum;
            r_sum_hi    <= n_sum_hi;
            r_count     <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: verif/spd_checker.sv
// Checker for the sensor packet deframer: predicts every result and compares it field by field.
module spd_checker
    import spd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic [2:0]  i_byte_role,
    input  logic        i_packet_last,
    input  logic        i_checksum_good,
    input  logic        i_forward_packet,
    input  logic        i_end_of_transfer,
    input  logic [7:0]  i_data_packet_count,
    output int          o_mismatch_count,
    output int          o_results_pending
);

    t_cfg        cfg;
    logic [2:0]  hunt_idx;
    logic        framing;
    logic [16:0] pos;
    logic [7:0]  ptype;
    logic [15:0] flen;
    logic [15:0] csum;
    logic [7:0]  sum_hi_byte;
    logic [7:0]  fwd_data_cnt;
    t_result     predicted_results[$];
    int          mismatches = 0;

    function automatic logic [7:0] sync_byte_at(input logic [2:0] idx);
        logic [47:0] sync;
        sync = {cfg.header_word, cfg.device_address};
        return sync[8 * (5 - idx) +: 8];
    endfunction

    function automatic int field_differs(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        t_result     r;
        logic [16:0] sum_hi_pos;
        logic [15:0] received;
        logic        type_ok;
        r = '0;
        r.out_byte = b;
        sum_hi_pos = {1'b0, flen} + 17'd1;
        if (!framing) begin
            if (b == sync_byte_at(hunt_idx)) begin
                if (hunt_idx == HUNT_LAST) begin
                    framing = 1'b1;
                    pos = '0;
                    hunt_idx = '0;
                end else begin
                    hunt_idx = hunt_idx + 3'd1;
                end
            end else begin
                hunt_idx = '0;
            end
        end else begin
            if (pos == 17'd0) begin
                ptype = b;
                csum = {8'h00, b};
                pos = 17'd1;
                r.byte_role = ROLE_TYPE;
            end else if (pos == 17'd1) begin
                flen = {b, 8'h00};
                csum = csum + {8'h00, b};
                pos = 17'd2;
                r.byte_role = ROLE_LEN_HI;
            end else if (pos == 17'd2) begin
                flen[7:0] = b;
                csum = csum + {8'h00, b};
                if (flen < 16'd2) begin
                    framing = 1'b0;
                    hunt_idx = '0;
                    pos = '0;
                    r.byte_role = ROLE_LEN_ERR;
                    r.packet_last = 1'b1;
                end else begin
                    pos = 17'd3;
                    r.byte_role = ROLE_LEN_LO;
                end
            end else if (pos < sum_hi_pos) begin
                csum = csum + {8'h00, b};
                pos = pos + 17'd1;
                r.byte_role = ROLE_PAYLOAD;
            end else if (pos == sum_hi_pos) begin
                sum_hi_byte = b;
                pos = pos + 17'd1;
                r.byte_role = ROLE_SUM_HI;
            end else begin
                received = {sum_hi_byte, b};
                type_ok = (ptype == TYPE_DATA) || (ptype == TYPE_END);
                r.byte_role = ROLE_SUM_LO;
                r.packet_last = 1'b1;
                r.checksum_good = (received == csum);
                r.forward_packet = (r.checksum_good || cfg.checksum_disabled) && type_ok;
                r.end_of_transfer = r.forward_packet && (ptype == TYPE_END);
                if (r.forward_packet && ptype == TYPE_DATA) begin
                    fwd_data_cnt = fwd_data_cnt + 8'd1;
                end
                framing = 1'b0;
                hunt_idx = '0;
                pos = '0;
            end
            r.data_packet_count = fwd_data_cnt;
            predicted_results.push_back(r);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (predicted_results.size() == 0) begin
            $error("result with no prediction waiting: out_byte %0h, byte_role %0d",
                   i_out_byte, i_byte_role);
            mismatches++;
        end else begin
            want = predicted_results.pop_front();
            mismatches += field_differs("out_byte", want.out_byte, i_out_byte);
            mismatches += field_differs("byte_role", want.byte_role, i_byte_role);
            mismatches += field_differs("packet_last", want.packet_last, i_packet_last);
            mismatches += field_differs("checksum_good", want.checksum_good, i_checksum_good);
            mismatches += field_differs("forward_packet", want.forward_packet,
                                        i_forward_packet);
            mismatches += field_differs("end_of_transfer", want.end_of_transfer,
                                        i_end_of_transfer);
            mismatches += field_differs("data_packet_count", want.data_packet_count,
                                        i_data_packet_count);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = '{header_word: RST_HEADER_WORD, device_address: RST_DEVICE_ADDRESS,
                    checksum_disabled: RST_CHECKSUM_DIS};
            hunt_idx = '0;
            framing = 1'b0;
            pos = '0;
            ptype = '0;
            flen = '0;
            csum = '0;
            sum_hi_byte = '0;
            fwd_data_cnt = '0;
            predicted_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEADER_WORD: begin
                        cfg.header_word = i_cfg_data[15:0];
                    end
                    CFG_DEVICE_ADDRESS: begin
                        cfg.device_address = i_cfg_data;
                    end
                    CFG_CHECKSUM_DIS: begin
                        cfg.checksum_disabled = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_rx_byte);
            end
        end
        o_results_pending <= predicted_results.size();
        o_mismatch_count <= mismatches;
    end

endmodule

FILE: verif/testbench.sv
// Top of the sensor packet deframer testbench: clock, reset, framed byte traffic and verdict.
module testbench;
    import spd_pkg::*;

    localparam int         PHASE_ITEMS   = 240;
    localparam int         PHASE_COUNT   = 6;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 6;
    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam int         STALL_NONE    = 0;
    localparam int         STALL_RANDOM  = 1;
    localparam int         STALL_RUNS    = 2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_HEADER_WORD;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_byte_role;
    logic        o_packet_last;
    logic        o_checksum_good;
    logic        o_forward_packet;
    logic        o_end_of_transfer;
    logic [7:0]  o_data_packet_count;
    int          mismatch_count;
    int          results_pending;

    logic [15:0] tx_header = RST_HEADER_WORD;
    logic [31:0] tx_address = RST_DEVICE_ADDRESS;
    int          item_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    int          idle_cycles = 0;
    int          stall_mode = STALL_NONE;
    int          stall_age = 0;
    int          stall_run = 0;
    logic        stall_level = 1'b0;

    always #5 i_clk = ~i_clk;

    sensor_packet_deframer u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_byte          (o_out_byte),
        .o_byte_role         (o_byte_role),
        .o_packet_last       (o_packet_last),
        .o_checksum_good     (o_checksum_good),
        .o_forward_packet    (o_forward_packet),
        .o_end_of_transfer   (o_end_of_transfer),
        .o_data_packet_count (o_data_packet_count)
    );

    spd_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_out_byte          (o_out_byte),
        .i_byte_role         (o_byte_role),
        .i_packet_last       (o_packet_last),
        .i_checksum_good     (o_checksum_good),
        .i_forward_packet    (o_forward_packet),
        .i_end_of_transfer   (o_end_of_transfer),
        .i_data_packet_count (o_data_packet_count),
        .o_mismatch_count    (mismatch_count),
        .o_results_pending   (results_pending)
    );

    always @(posedge i_clk) begin
        logic next_stall;
        if (stall_age == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
            stall_age = $urandom_range(50, 300);
        end else begin
            stall_age--;
        end
        case (stall_mode)
            STALL_NONE: begin
                next_stall = 1'b0;
            end
            STALL_RANDOM: begin
                next_stall = ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (stall_run == 0) begin
                    stall_level = ~stall_level;
                    stall_run = $urandom_range(1, 8);
                end
                stall_run--;
                next_stall = stall_level;
            end
        endcase
        i_out_stall <= next_stall;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL sensor_packet_deframer");
            $finish;
        end
    end

    function automatic logic [7:0] hunt_seq(input int idx);
        logic [47:0] sync;
        sync = {tx_header, tx_address};
        return sync[8 * (5 - idx) +: 8];
    endfunction

    // A byte that matches no position of the hunt, so it always sends the hunt back to start.
    function automatic logic [7:0] pick_noise();
        logic [7:0] v;
        bit         clash;
        do begin
            v = 8'($urandom_range(0, 255));
            clash = 1'b0;
            for (int k = 0; k < 6; k++) begin
                if (v == hunt_seq(k)) begin
                    clash = 1'b1;
                end
            end
        end while (clash);
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] value, input bit counted);
        i_in_valid <= 1'b1;
        i_rx_byte <= value;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (counted) begin
            item_count++;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_header(input int count);
        for (int k = 0; k < count; k++) begin
            send_byte(hunt_seq(k), 1'b1);
        end
    endtask

    task automatic send_packet(input logic [7:0] ptype, input logic [15:0] len,
                               input bit sum_ok);
        logic [15:0] sum;
        logic [7:0]  b;
        send_header(6);
        sum = {8'h00, ptype} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
        send_byte(ptype, 1'b1);
        send_byte(len[15:8], 1'b1);
        send_byte(len[7:0], 1'b1);
        if (len >= 16'd2) begin
            for (int k = 2; k < len; k++) begin
                b = 8'($urandom_range(0, 255));
                sum = sum + {8'h00, b};
                send_byte(b, 1'b1);
            end
            if (!sum_ok) begin
                sum = sum ^ 16'($urandom_range(1, 65535));
            end
            send_byte(sum[15:8], 1'b1);
            send_byte(sum[7:0], 1'b1);
        end
    endtask

    task automatic random_sequence();
        int          pick;
        logic [7:0]  ptype;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        gaps_on = ($urandom_range(0, 4) != 0);
        if (pick < 8) begin
            repeat ($urandom_range(1, 4)) send_byte(pick_noise(), 1'b0);
        end else if (pick < 16) begin
            send_header($urandom_range(1, 5));
            send_byte(pick_noise(), 1'b1);
        end else if (pick < 22) begin
            send_packet(8'($urandom_range(0, 255)), 16'($urandom_range(0, 1)), 1'b1);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ptype = TYPE_DATA;
                4, 5:       ptype = TYPE_END;
                6:          ptype = 8'h00;
                7:          ptype = 8'hFF;
                default:    ptype = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 9) == 0) begin
                len = 16'($urandom_range(13, 40));
            end else begin
                len = 16'($urandom_range(2, 12));
            end
            send_packet(ptype, len, $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        if (idx == CFG_HEADER_WORD) begin
            tx_header = value[15:0];
        end else if (idx == CFG_DEVICE_ADDRESS) begin
            tx_address = value;
        end
        @(posedge i_clk);
    endtask

    task automatic configure(input int phase);
        case (phase)
            1: begin
                write_reg(CFG_HEADER_WORD, 32'h0000_0000);
                write_reg(CFG_DEVICE_ADDRESS, 32'h0000_0000);
                write_reg(CFG_CHECKSUM_DIS, 32'd0);
            end
            2: begin
                write_reg(CFG_HEADER_WORD, 32'h0000_FFFF);
                write_reg(CFG_DEVICE_ADDRESS, 32'hFFFF_FFFF);
                write_reg(CFG_CHECKSUM_DIS, 32'd1);
                write_reg(CFG_SPARE, $urandom);
            end
            3: begin
                write_reg(CFG_HEADER_WORD, $urandom_range(0, 65535));
                write_reg(CFG_DEVICE_ADDRESS, $urandom);
                write_reg(CFG_CHECKSUM_DIS, 32'd0);
            end
            4: begin
                write_reg(CFG_HEADER_WORD, $urandom_range(0, 65535));
                write_reg(CFG_DEVICE_ADDRESS, $urandom);
                write_reg(CFG_CHECKSUM_DIS, 32'd1);
            end
            default: begin
                write_reg(CFG_HEADER_WORD, {16'h0000, RST_HEADER_WORD});
                write_reg(CFG_DEVICE_ADDRESS, $urandom);
                write_reg(CFG_CHECKSUM_DIS, 32'd0);
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int phase_end;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A stray byte, then a first header byte seen twice: the second one is not retried.
        send_byte(8'h00, 1'b1);
        send_byte(hunt_seq(0), 1'b1);
        send_byte(hunt_seq(0), 1'b1);
        send_byte(hunt_seq(1), 1'b1);
        send_packet(TYPE_DATA, 16'd2, 1'b1);
        send_packet(8'hFF, 16'd0, 1'b1);
        send_packet(TYPE_END, 16'd3, 1'b0);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase != 0) begin
                drain_results();
                configure(phase);
            end
            if (phase == PHASE_COUNT - 1) begin
                send_packet(TYPE_DATA, 16'h0102, 1'b1);
            end
            phase_end = item_count + PHASE_ITEMS;
            while (item_count < phase_end) begin
                random_sequence();
            end
        end
        drain_results();

        if (mismatch_count == 0 && results_pending == 0) begin
            $display("PASS sensor_packet_deframer");
        end else begin
            $display("FAIL sensor_packet_deframer");
        end
        $finish;
    end

endmodule
